FILE: rtl/ssrf_pkg.sv
package ssrf_pkg;

  // default bank sizes and thread id width
  localparam int DEF_INT_REGS       = 1024;
  localparam int DEF_FLT_REGS       = 128;
  localparam int DEF_THREAD_ID_BITS = 8;

  // field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int SYNC_W  = 2;
  localparam int VAL_W   = 64;
  localparam int TID_W   = 8;
  localparam int SIZE_W  = 4;
  localparam int TAG_W   = 44;
  localparam int STAT_W  = 3;
  localparam int ENTRY_W = SYNC_W + VAL_W;

  // sweep pointer and remaining count, wide enough for index plus count
  // and for the largest bank
  localparam int SWP_W = 13;

  // sync states
  localparam logic [SYNC_W-1:0] SYNC_EMPTY   = 2'd0;
  localparam logic [SYNC_W-1:0] SYNC_PENDING = 2'd1;
  localparam logic [SYNC_W-1:0] SYNC_WAITING = 2'd2;
  localparam logic [SYNC_W-1:0] SYNC_FULL    = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_RANGE      = 3'd1,
    ST_RESET_WAIT = 3'd2,
    ST_MEM_PEND   = 3'd3,
    ST_WAKE_STALL = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take a request and read the entry
    logic exec;     // evaluate the captured request
    logic emit;     // load the result registers
    logic load;     // load the sweep pointer from the request
    logic sweep;    // write an empty entry at the sweep pointer
    logic init;     // sweep covers both banks after reset
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_go;    // in-range clear with a nonzero count
    logic sweep_last;  // last entry of the sweep
  } stat_t;

endpackage

FILE: rtl/sync_state_register_file.sv
// read and write: result strobe from the result registers once the captured request is
// evaluated; busy meanwhile, as the bank read is registered before the checked write
// range clear: one entry emptied per cycle over the single write port
// reset: a clearing pass over max(INT_REGS, FLT_REGS) entries empties both banks, busy high
// results are shown for one cycle and the receiver cannot stall
module sync_state_register_file
  import ssrf_pkg::*;
#(
  parameter int INT_REGS       = DEF_INT_REGS,
  parameter int FLT_REGS       = DEF_FLT_REGS,
  parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic              reg_class_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [SYNC_W-1:0] new_state_i,
  input  logic [VAL_W-1:0]  new_value_i,
  input  logic [TID_W-1:0]  wait_head_i,
  input  logic [TID_W-1:0]  wait_tail_i,
  input  logic [SIZE_W-1:0] mem_size_i,
  input  logic [TAG_W-1:0]  mem_tag_i,
  input  logic              from_memory_i,
  input  logic              allocator_ready_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [SYNC_W-1:0] read_state_o,
  output logic [VAL_W-1:0]  read_value_o,
  output logic [TID_W-1:0]  read_wait_head_o,
  output logic [TID_W-1:0]  read_wait_tail_o,
  output logic [SIZE_W-1:0] read_mem_size_o,
  output logic [TAG_W-1:0]  read_mem_tag_o,
  output logic              wake_request_o,
  output logic [TID_W-1:0]  wake_head_o,
  output logic [TID_W-1:0]  wake_tail_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing of requests and sweeps
  ssrf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // banks, checks and result registers
  ssrf_datapath #(
    .INT_REGS       (INT_REGS),
    .FLT_REGS       (FLT_REGS),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .operation_i       (operation_i),
    .reg_class_i       (reg_class_i),
    .index_i           (index_i),
    .count_i           (count_i),
    .new_state_i       (new_state_i),
    .new_value_i       (new_value_i),
    .wait_head_i       (wait_head_i),
    .wait_tail_i       (wait_tail_i),
    .mem_size_i        (mem_size_i),
    .mem_tag_i         (mem_tag_i),
    .from_memory_i     (from_memory_i),
    .allocator_ready_i (allocator_ready_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .read_state_o      (read_state_o),
    .read_value_o      (read_value_o),
    .read_wait_head_o  (read_wait_head_o),
    .read_wait_tail_o  (read_wait_tail_o),
    .read_mem_size_o   (read_mem_size_o),
    .read_mem_tag_o    (read_mem_tag_o),
    .wake_request_o    (wake_request_o),
    .wake_head_o       (wake_head_o),
    .wake_tail_o       (wake_tail_o)
  );

endmodule

FILE: rtl/ssrf_ctrl.sv
module ssrf_ctrl
  import ssrf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        cmd_o.init  = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.clear_go) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLEAR;
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register, reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // an accepted request is evaluated in the next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_EXEC))
    else $error("accepted request not evaluated");

  // a range clear sweep only follows evaluation
  a_clear_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_CLEAR))
    else $error("clear sweep entered without a request");

  // the last entry of a clear sweep returns to idle
  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && stat_i.sweep_last) |=> (state_q == S_IDLE))
    else $error("clear sweep did not finish");

endmodule

FILE: rtl/ssrf_datapath.sv
module ssrf_datapath
  import ssrf_pkg::*;
#(
  parameter int INT_REGS       = DEF_INT_REGS,
  parameter int FLT_REGS       = DEF_FLT_REGS,
  parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic              reg_class_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [SYNC_W-1:0] new_state_i,
  input  logic [VAL_W-1:0]  new_value_i,
  input  logic [TID_W-1:0]  wait_head_i,
  input  logic [TID_W-1:0]  wait_tail_i,
  input  logic [SIZE_W-1:0] mem_size_i,
  input  logic [TAG_W-1:0]  mem_tag_i,
  input  logic              from_memory_i,
  input  logic              allocator_ready_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [SYNC_W-1:0] read_state_o,
  output logic [VAL_W-1:0]  read_value_o,
  output logic [TID_W-1:0]  read_wait_head_o,
  output logic [TID_W-1:0]  read_wait_tail_o,
  output logic [SIZE_W-1:0] read_mem_size_o,
  output logic [TAG_W-1:0]  read_mem_tag_o,
  output logic              wake_request_o,
  output logic [TID_W-1:0]  wake_head_o,
  output logic [TID_W-1:0]  wake_tail_o
);

  localparam int IAW      = (INT_REGS > 1) ? $clog2(INT_REGS) : 1;
  localparam int FAW      = (FLT_REGS > 1) ? $clog2(FLT_REGS) : 1;
  localparam int MAX_REGS = (INT_REGS > FLT_REGS) ? INT_REGS : FLT_REGS;

  // low thread id bits all ones means no thread
  localparam logic [TID_W-1:0] TID_MASK = TID_W'((1 << THREAD_ID_BITS) - 1);
  localparam bit               TID_FITS = (THREAD_ID_BITS <= TID_W);

  localparam logic [VAL_W-1:0] EMPTY_PAY = {TID_MASK, TID_MASK, {SIZE_W{1'b0}},
                                            {TAG_W{1'b0}}};

  // captured request
  logic [OP_W-1:0]   op_q;
  logic              cls_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SYNC_W-1:0] nst_q;
  logic [VAL_W-1:0]  nval_q;
  logic [TID_W-1:0]  nhead_q, ntail_q;
  logic [SIZE_W-1:0] nsize_q;
  logic [TAG_W-1:0]  ntag_q;
  logic              frommem_q, ready_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= operation_i;
      cls_q     <= reg_class_i;
      idx_q     <= index_i;
      cnt_q     <= count_i;
      nst_q     <= new_state_i;
      nval_q    <= new_value_i;
      nhead_q   <= wait_head_i;
      ntail_q   <= wait_tail_i;
      nsize_q   <= mem_size_i;
      ntag_q    <= mem_tag_i;
      frommem_q <= from_memory_i;
      ready_q   <= allocator_ready_i;
    end
  end

  // sweep pointer and remaining count, reset value covers the clearing pass
  logic [SWP_W-1:0] ptr_q, rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      rem_q <= SWP_W'(MAX_REGS);
    end else if (cmd_i.load) begin
      ptr_q <= SWP_W'(idx_q);
      rem_q <= SWP_W'(cnt_q);
    end else if (cmd_i.sweep) begin
      ptr_q <= ptr_q + 1'b1;
      rem_q <= rem_q - 1'b1;
    end
  end

  assign stat_o.sweep_last = (rem_q == SWP_W'(1));

  // bank memories
  logic [ENTRY_W-1:0] int_mem [INT_REGS];
  logic [ENTRY_W-1:0] flt_mem [FLT_REGS];
  logic [ENTRY_W-1:0] int_rd_q, flt_rd_q;
  logic [ENTRY_W-1:0] wdata;
  logic               int_we, flt_we;
  logic [IAW-1:0]     int_wa;
  logic [FAW-1:0]     flt_wa;
  logic               wr_ok;

  assign int_wa = cmd_i.sweep ? IAW'(ptr_q) : IAW'(idx_q);
  assign flt_wa = cmd_i.sweep ? FAW'(ptr_q) : FAW'(idx_q);

  assign int_we = (cmd_i.exec && wr_ok && !cls_q) ||
                  (cmd_i.sweep && (cmd_i.init ? (ptr_q < SWP_W'(INT_REGS)) : !cls_q));
  assign flt_we = (cmd_i.exec && wr_ok && cls_q) ||
                  (cmd_i.sweep && (cmd_i.init ? (ptr_q < SWP_W'(FLT_REGS)) : cls_q));

  always_ff @(posedge clk_i) begin
    if (int_we) begin
      int_mem[int_wa] <= wdata;
    end
    if (cmd_i.capture) begin
      int_rd_q <= int_mem[IAW'(index_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flt_we) begin
      flt_mem[flt_wa] <= wdata;
    end
    if (cmd_i.capture) begin
      flt_rd_q <= flt_mem[FAW'(index_i)];
    end
  end

  // current entry fields
  logic [SYNC_W-1:0] cur_state;
  logic [VAL_W-1:0]  cur_pay;
  logic [TID_W-1:0]  cur_head, cur_tail;
  logic [SIZE_W-1:0] cur_size;
  logic [TAG_W-1:0]  cur_tag;
  logic [SWP_W-1:0]  bank_size;
  logic              idx_ok, clr_ok, head_live;

  assign cur_state = cls_q ? flt_rd_q[ENTRY_W-1 -: SYNC_W] : int_rd_q[ENTRY_W-1 -: SYNC_W];
  assign cur_pay   = cls_q ? flt_rd_q[VAL_W-1:0] : int_rd_q[VAL_W-1:0];
  assign cur_head  = cur_pay[VAL_W-1 -: TID_W];
  assign cur_tail  = cur_pay[VAL_W-TID_W-1 -: TID_W];
  assign cur_size  = cur_pay[TAG_W+SIZE_W-1 -: SIZE_W];
  assign cur_tag   = cur_pay[TAG_W-1:0];

  assign bank_size = cls_q ? SWP_W'(FLT_REGS) : SWP_W'(INT_REGS);
  assign idx_ok    = (SWP_W'(idx_q) < bank_size);
  assign clr_ok    = ((SWP_W'(idx_q) + SWP_W'(cnt_q)) <= bank_size);
  assign head_live = !(TID_FITS && ((cur_head & TID_MASK) == TID_MASK));

  // new entry for a write, empty entry for a sweep
  assign wdata = !cmd_i.exec         ? {SYNC_EMPTY, EMPTY_PAY} :
                 (nst_q == SYNC_FULL) ? {SYNC_FULL, nval_q} :
                                        {nst_q, nhead_q, ntail_q, nsize_q, ntag_q};

  // request evaluation
  status_e           res_status;
  logic [SYNC_W-1:0] res_state;
  logic [VAL_W-1:0]  res_value;
  logic [TID_W-1:0]  res_head, res_tail, res_whead, res_wtail;
  logic [SIZE_W-1:0] res_size;
  logic [TAG_W-1:0]  res_tag;
  logic              res_wake, clear_go;

  always_comb begin
    res_status = ST_OK;
    res_state  = '0;
    res_value  = '0;
    res_head   = '0;
    res_tail   = '0;
    res_size   = '0;
    res_tag    = '0;
    res_wake   = 1'b0;
    res_whead  = '0;
    res_wtail  = '0;
    wr_ok      = 1'b0;
    clear_go   = 1'b0;
    case (op_q)
      OP_READ: begin
        if (!idx_ok) begin
          res_status = ST_RANGE;
        end else begin
          res_state = cur_state;
          if (cur_state == SYNC_FULL) begin
            res_value = cur_pay;
          end else begin
            res_head = cur_head;
            res_tail = cur_tail;
            res_size = cur_size;
            res_tag  = cur_tag;
          end
        end
      end
      OP_WRITE: begin
        if (!idx_ok) begin
          res_status = ST_RANGE;
        end else if (cur_state == SYNC_WAITING && nst_q == SYNC_EMPTY) begin
          res_status = ST_RESET_WAIT;
        end else if (cur_state != SYNC_FULL && cur_size != '0 && !frommem_q &&
                     (nst_q == SYNC_FULL || nsize_q != cur_size || ntag_q != cur_tag)) begin
          res_status = ST_MEM_PEND;
        end else if (cur_state == SYNC_WAITING && nst_q == SYNC_FULL && head_live) begin
          if (!ready_q) begin
            res_status = ST_WAKE_STALL;
          end else begin
            res_wake  = 1'b1;
            res_whead = cur_head;
            res_wtail = cur_tail;
            wr_ok     = 1'b1;
          end
        end else begin
          wr_ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (!clr_ok) begin
          res_status = ST_RANGE;
        end else if (cnt_q != '0) begin
          clear_go = 1'b1;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign stat_o.clear_go = clear_go;

  // result registers, a finished sweep reports ok with empty fields
  logic              done_q;
  logic [STAT_W-1:0] status_q;
  logic [SYNC_W-1:0] rstate_q;
  logic [VAL_W-1:0]  rvalue_q;
  logic [TID_W-1:0]  rhead_q, rtail_q, whead_q, wtail_q;
  logic [SIZE_W-1:0] rsize_q;
  logic [TAG_W-1:0]  rtag_q;
  logic              wake_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.exec) begin
        status_q <= res_status;
        rstate_q <= res_state;
        rvalue_q <= res_value;
        rhead_q  <= res_head;
        rtail_q  <= res_tail;
        rsize_q  <= res_size;
        rtag_q   <= res_tag;
        wake_q   <= res_wake;
        whead_q  <= res_whead;
        wtail_q  <= res_wtail;
      end else begin
        status_q <= ST_OK;
        rstate_q <= '0;
        rvalue_q <= '0;
        rhead_q  <= '0;
        rtail_q  <= '0;
        rsize_q  <= '0;
        rtag_q   <= '0;
        wake_q   <= 1'b0;
        whead_q  <= '0;
        wtail_q  <= '0;
      end
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign read_state_o     = rstate_q;
  assign read_value_o     = rvalue_q;
  assign read_wait_head_o = rhead_q;
  assign read_wait_tail_o = rtail_q;
  assign read_mem_size_o  = rsize_q;
  assign read_mem_tag_o   = rtag_q;
  assign wake_request_o   = wake_q;
  assign wake_head_o      = whead_q;
  assign wake_tail_o      = wtail_q;

  // result strobes never come back to back
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // a wake only comes with a successful write
  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && wake_request_o) |-> (status_o == ST_OK))
    else $error("wake issued with an error status");

  // a range clear sweep never runs past its count
  a_sweep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep && !cmd_i.init) |-> (rem_q != '0))
    else $error("clear sweep past its count");

endmodule
